@@ hdl/sfr_pkg.sv @@
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared widths, register indexes and reset values of the serial frame
// receiver.
// ----------------------------------------------------------------------------
package sfr_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned IndexW  = 9;
  localparam int unsigned FieldW  = 8;
  localparam int unsigned CfgIdxW = 3;

  localparam int unsigned DefAddrBytes = 4;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegMainHeader = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMainEnd    = 3'd1;
  localparam logic [CfgIdxW-1:0] RegKeyHeader  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegKeyCmdA    = 3'd3;
  localparam logic [CfgIdxW-1:0] RegKeyCmdB    = 3'd4;
  localparam logic [CfgIdxW-1:0] RegMainMaxLen = 3'd5;
  localparam logic [CfgIdxW-1:0] RegKeyMaxLen  = 3'd6;

  // Reset values
  localparam logic [ByteW-1:0] RstMainHeader = 8'd172;
  localparam logic [ByteW-1:0] RstMainEnd    = 8'd0;
  localparam logic [ByteW-1:0] RstKeyHeader  = 8'd104;
  localparam logic [ByteW-1:0] RstKeyCmdA    = 8'd32;
  localparam logic [ByteW-1:0] RstKeyCmdB    = 8'd33;
  localparam logic [ByteW-1:0] RstMainMaxLen = 8'd64;
  localparam logic [ByteW-1:0] RstKeyMaxLen  = 8'd64;

  // Number of check bytes in a main frame
  localparam logic [FieldW-1:0] MainCheckBytes = 8'd2;

endpackage

@@ hdl/serial_frame_receiver_unit.sv @@
// An accepted item passes the input register, then the result register, to the output.
// Throughput: one item per cycle while the output is not stalled;
// the phase update is a single pass of logic.
// in_stall_o rises only while the result register is full and stalled.
// Reset (rst_ni low, asynchronous): control registers reset, hunting for a header.
// ----------------------------------------------------------------------------
// serial_frame_receiver_unit
// Byte-wise receiver for length-prefixed main and key-load frames; reports
// each byte with its frame position, completion, abort and in-frame status.
// ----------------------------------------------------------------------------
module serial_frame_receiver_unit #(
  parameter int unsigned AddrBytes = sfr_pkg::DefAddrBytes
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // Configuration write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [sfr_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [sfr_pkg::ByteW-1:0]    cfg_data_i,
  // Input channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [sfr_pkg::ByteW-1:0]    rx_byte_i,
  // Output channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         stored_o,
  output logic [sfr_pkg::IndexW-1:0]   byte_index_o,
  output logic [sfr_pkg::ByteW-1:0]    byte_value_o,
  output logic                         frame_kind_o,
  output logic                         frame_done_o,
  output logic                         frame_abort_o,
  output logic                         in_frame_o
);

  typedef enum logic [3:0] {
    PhHunt, PhAddr, PhSeq, PhCmd, PhLen, PhData, PhCs, PhEnd,
    PhKcmd, PhKlen, PhKdata, PhKcs1, PhKcs2
  } phase_e;

  // Configuration registers
  logic [sfr_pkg::ByteW-1:0] main_hdr_q, main_end_q, key_hdr_q;
  logic [sfr_pkg::ByteW-1:0] key_cmd_a_q, key_cmd_b_q, main_max_q, key_max_q;

  // Input register
  logic                      in_vld_q;
  logic [sfr_pkg::ByteW-1:0] rx_q;

  // Frame state
  phase_e                     phase_q, phase_d;
  logic [sfr_pkg::IndexW-1:0] frame_cnt_q, frame_cnt_d;
  logic [sfr_pkg::FieldW-1:0] field_cnt_q, field_cnt_d;
  logic [sfr_pkg::FieldW-1:0] data_len_q, data_len_d;

  // Result register
  logic                       out_vld_q;
  logic                       stored_q, kind_q, done_q, abort_q, in_frame_q;
  logic [sfr_pkg::IndexW-1:0] index_q;
  logic [sfr_pkg::ByteW-1:0]  value_q;

  logic                       advance;
  logic                       keep, done, abrt, kind;
  logic [sfr_pkg::IndexW-1:0] idx;
  logic [sfr_pkg::FieldW-1:0] field_inc;

  assign cfg_ready_o = 1'b1;

  // Move the held item into the result register whenever that register frees up
  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      main_hdr_q  <= sfr_pkg::RstMainHeader;
      main_end_q  <= sfr_pkg::RstMainEnd;
      key_hdr_q   <= sfr_pkg::RstKeyHeader;
      key_cmd_a_q <= sfr_pkg::RstKeyCmdA;
      key_cmd_b_q <= sfr_pkg::RstKeyCmdB;
      main_max_q  <= sfr_pkg::RstMainMaxLen;
      key_max_q   <= sfr_pkg::RstKeyMaxLen;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        sfr_pkg::RegMainHeader: main_hdr_q  <= cfg_data_i;
        sfr_pkg::RegMainEnd:    main_end_q  <= cfg_data_i;
        sfr_pkg::RegKeyHeader:  key_hdr_q   <= cfg_data_i;
        sfr_pkg::RegKeyCmdA:    key_cmd_a_q <= cfg_data_i;
        sfr_pkg::RegKeyCmdB:    key_cmd_b_q <= cfg_data_i;
        sfr_pkg::RegMainMaxLen: main_max_q  <= cfg_data_i;
        sfr_pkg::RegKeyMaxLen:  key_max_q   <= cfg_data_i;
        default: ;  // drop writes past the register list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      rx_q <= rx_byte_i;
    end
  end

  assign field_inc = field_cnt_q + 1'b1;

  always_comb begin
    phase_d     = phase_q;
    frame_cnt_d = frame_cnt_q;
    field_cnt_d = field_cnt_q;
    data_len_d  = data_len_q;
    keep        = 1'b0;
    done        = 1'b0;
    abrt        = 1'b0;
    idx         = frame_cnt_q;
    kind        = (phase_q == PhKcmd) || (phase_q == PhKlen) || (phase_q == PhKdata) ||
                  (phase_q == PhKcs1) || (phase_q == PhKcs2);

    unique case (phase_q)
      PhHunt: begin
        if (rx_q == main_hdr_q) begin
          kind        = 1'b0;
          idx         = '0;
          keep        = 1'b1;
          field_cnt_d = '0;
          phase_d     = PhAddr;
        end else if (rx_q == key_hdr_q) begin
          kind    = 1'b1;
          idx     = '0;
          keep    = 1'b1;
          phase_d = PhKcmd;
        end
      end
      PhAddr: begin
        keep        = 1'b1;
        field_cnt_d = field_inc;
        if (field_inc >= sfr_pkg::FieldW'(AddrBytes)) phase_d = PhSeq;
      end
      PhSeq: begin
        keep    = 1'b1;
        phase_d = PhCmd;
      end
      PhCmd: begin
        keep    = 1'b1;
        phase_d = PhLen;
      end
      PhLen: begin
        if (rx_q > main_max_q) begin
          abrt = 1'b1;
        end else begin
          keep        = 1'b1;
          data_len_d  = rx_q;
          field_cnt_d = '0;
          phase_d     = (rx_q == '0) ? PhCs : PhData;
        end
      end
      PhData: begin
        keep        = 1'b1;
        field_cnt_d = field_inc;
        if (field_inc >= data_len_q) begin
          field_cnt_d = '0;
          phase_d     = PhCs;
        end
      end
      PhCs: begin
        keep        = 1'b1;
        field_cnt_d = field_inc;
        if (field_inc >= sfr_pkg::MainCheckBytes) phase_d = PhEnd;
      end
      PhEnd: begin
        if (rx_q == main_end_q) begin
          keep = 1'b1;
          done = 1'b1;
        end else begin
          abrt = 1'b1;
        end
      end
      PhKcmd: begin
        if (rx_q == key_cmd_a_q || rx_q == key_cmd_b_q) begin
          keep    = 1'b1;
          phase_d = PhKlen;
        end else begin
          abrt = 1'b1;
        end
      end
      PhKlen: begin
        if (rx_q > key_max_q) begin
          abrt = 1'b1;
        end else begin
          keep        = 1'b1;
          data_len_d  = rx_q;
          field_cnt_d = '0;
          phase_d     = (rx_q == '0) ? PhKcs1 : PhKdata;
        end
      end
      PhKdata: begin
        keep        = 1'b1;
        field_cnt_d = field_inc;
        if (field_inc >= data_len_q) begin
          field_cnt_d = '0;
          phase_d     = PhKcs1;
        end
      end
      PhKcs1: begin
        keep    = 1'b1;
        phase_d = PhKcs2;
      end
      PhKcs2: begin
        keep = 1'b1;
        done = 1'b1;
      end
      default: phase_d = PhHunt;
    endcase

    if (keep) frame_cnt_d = idx + 1'b1;
    if (done || abrt) phase_d = PhHunt;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHunt;
      frame_cnt_q <= '0;
      field_cnt_q <= '0;
      data_len_q  <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      if (advance) begin
        phase_q     <= phase_d;
        frame_cnt_q <= frame_cnt_d;
        field_cnt_q <= field_cnt_d;
        data_len_q  <= data_len_d;
        out_vld_q   <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      stored_q   <= keep;
      index_q    <= keep ? idx : '0;
      value_q    <= keep ? rx_q : '0;
      kind_q     <= (keep || abrt) ? kind : 1'b0;
      done_q     <= done;
      abort_q    <= abrt;
      in_frame_q <= (phase_d != PhHunt);
    end
  end

  assign out_valid_o   = out_vld_q;
  assign stored_o      = stored_q;
  assign byte_index_o  = index_q;
  assign byte_value_o  = value_q;
  assign frame_kind_o  = kind_q;
  assign frame_done_o  = done_q;
  assign frame_abort_o = abort_q;
  assign in_frame_o    = in_frame_q;

endmodule

@@ hdl/sfr_checker.sv @@
// ----------------------------------------------------------------------------
// sfr_checker
// Port-level checks on the serial frame receiver's result channel.
// ----------------------------------------------------------------------------
module sfr_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic                         stored_o,
  input logic [sfr_pkg::IndexW-1:0]   byte_index_o,
  input logic [sfr_pkg::ByteW-1:0]    byte_value_o,
  input logic                         frame_done_o,
  input logic                         frame_abort_o,
  input logic                         in_frame_o
);

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(byte_index_o)
      && $stable(byte_value_o) && $stable(stored_o))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(frame_done_o && frame_abort_o))
    else $error("frame both completed and aborted");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !stored_o |-> byte_index_o == '0 && byte_value_o == '0)
    else $error("unstored item carries position or value");

  // A finished or rejected frame leaves the receiver hunting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (frame_done_o || frame_abort_o) |-> !in_frame_o)
    else $error("in-frame flag set after frame end");

endmodule

bind serial_frame_receiver_unit sfr_checker u_sfr_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .stored_o      (stored_o),
  .byte_index_o  (byte_index_o),
  .byte_value_o  (byte_value_o),
  .frame_done_o  (frame_done_o),
  .frame_abort_o (frame_abort_o),
  .in_frame_o    (in_frame_o)
);
